[sv/toroidal_life_generation_unit_assert.svh]
// Assertion macros shared by the toroidal life generation RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TOROIDAL_LIFE_GENERATION_UNIT_ASSERT_SVH
`define TOROIDAL_LIFE_GENERATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TLG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tlg_pkg.sv]
// Shared types and constants for the toroidal life generation unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tlg_pkg;

    // Grid geometry
    localparam int ROWS   = 32;
    localparam int COLS   = 64;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int NR_W   = 6;
    localparam int NC_W   = 7;
    localparam int COL_W  = $clog2(COLS);
    localparam int DATA_W = ((ROW_W + COLS + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - ROW_W - COLS;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = NC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);
    localparam logic [NR_W-1:0] RESET_ROWS = NR_W'(25);
    localparam logic [NC_W-1:0] RESET_COLS = NC_W'(64);
    localparam int MIN_DIM = 3;

    // Operation codes carried on the input tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // B3/S23 rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Row control handed from the sequencer to the merge stage
    typedef struct packed {
        logic             fire;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
    } t_row_ctl;

endpackage

[sv/tlg_row_mem.sv]
// Cell grid storage: one write port, one registered read port, per-row valid bits.
// Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_row_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [tlg_pkg::ROW_W-1:0] i_waddr,
    input  logic [tlg_pkg::COLS-1:0]  i_wdata,
    input  logic                      i_re,
    input  logic [tlg_pkg::ROW_W-1:0] i_raddr,
    output logic [tlg_pkg::COLS-1:0]  o_rdata
);
    import tlg_pkg::*;

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [COLS-1:0] r_rdata;
    logic            r_rd_ok;

    // Write the row array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Mark written rows; reset makes every row read as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_row_vld[i_raddr];
            end
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

[sv/tlg_lane.sv]
// One column lane: counts the eight neighbors and applies the B3/S23 rule.
// Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_lane (
    input  logic [7:0] i_nbrs,
    input  logic       i_alive,
    output logic       o_next
);
    import tlg_pkg::*;

    logic [3:0] cnt;

    // Sum the neighbor bits
    always_comb begin
        cnt = 4'd0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, i_nbrs[k]};
        end
    end

    assign o_next = (cnt == BIRTH_COUNT) || (i_alive && (cnt == SURVIVE_COUNT));

endmodule

[sv/tlg_merge.sv]
// Merge stage: gathers lane results into a row, tracks stability, holds the output register.
// Depends on tlg_pkg.
`timescale 1ns / 1ps

module tlg_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tlg_pkg::t_row_ctl         i_ctl,
    input  logic [tlg_pkg::COLS-1:0]  i_lanes,
    input  logic [tlg_pkg::COLS-1:0]  i_mask,
    input  logic [tlg_pkg::COLS-1:0]  i_mid,
    input  logic                      i_ready,
    output logic [tlg_pkg::COLS-1:0]  o_row_next,
    output logic                      o_valid,
    output logic [tlg_pkg::ROW_W-1:0] o_row_idx,
    output logic [tlg_pkg::COLS-1:0]  o_row_cells,
    output logic                      o_last,
    output logic                      o_stable
);
    import tlg_pkg::*;

    logic             r_valid;
    logic             r_same;
    logic [ROW_W-1:0] r_row_idx;
    logic [COLS-1:0]  r_row_cells;
    logic             r_last;
    logic             r_stable;
    logic             go;
    logic             match;
    logic             same_now;

    // Combine lanes and compare with the old row
    assign go         = !r_valid || i_ready;
    assign o_row_next = i_lanes & i_mask;
    assign match      = (o_row_next == i_mid);
    assign same_now   = i_ctl.first ? match : (r_same && match);

    // Output valid and running stability flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_same  <= 1'b1;
        end else if (go) begin
            r_valid <= i_ctl.fire;
            if (i_ctl.fire) begin
                r_same <= same_now;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (go && i_ctl.fire) begin
            r_row_idx   <= i_ctl.row;
            r_row_cells <= o_row_next;
            r_last      <= i_ctl.last;
            r_stable    <= i_ctl.last && same_now;
        end
    end

    assign o_valid     = r_valid;
    assign o_row_idx   = r_row_idx;
    assign o_row_cells = r_row_cells;
    assign o_last      = r_last;
    assign o_stable    = r_stable;

endmodule

[sv/toroidal_life_generation_unit.sv]
// Top level of the toroidal life generation unit: sequencer, row window, 64 lanes.
// Depends on tlg_pkg, tlg_row_mem, tlg_lane, tlg_merge and the assertion macro header.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  s       | in        | i_s_tvalid/o_s_tready | tdata: row_index, row_cells; tuser: op
//  m       | out       | o_m_tvalid/i_m_tready | tdata: out_row_index, out_row_cells;
//          |           |                       | tlast: last_row; tuser: stable
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// An advance streams rows nr-1, 0 .. nr-1 out of the single read port of the grid memory
// into a three-row window; the lanes then give one new row per cycle while the output is
// not stalled. Reset is synchronous, clears the grid to dead cells and loads rows 25,
// cols 64. A stalled output freezes the whole row pipeline in place.
`timescale 1ns / 1ps
`include "toroidal_life_generation_unit_assert.svh"

module toroidal_life_generation_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: [4:0] row_index, [68:5] row_cells, [71:69] zero
    input  logic [tlg_pkg::DATA_W-1:0]     i_s_tdata,
    // tuser: [0] operation
    input  logic                           i_s_tuser,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: [4:0] out_row_index, [68:5] out_row_cells, [71:69] zero
    output logic [tlg_pkg::DATA_W-1:0]     o_m_tdata,
    // tuser: [0] stable
    output logic                           o_m_tuser,
    output logic                           o_m_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tlg_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [NR_W-1:0]  r_cfg_rows;
    logic [NC_W-1:0]  r_cfg_cols;
    logic [NR_W-1:0]  nr;
    logic [NR_W-1:0]  nr_p1;
    logic [NC_W-1:0]  nc;
    logic [COL_W-1:0] last_col;
    logic [COLS-1:0]  col_mask;
    logic             go;
    logic             s_accept;
    logic [ROW_W-1:0] s_row_index;
    logic [COLS-1:0]  s_row_cells;
    logic             load_we;

    logic [NR_W-1:0]  r_iss_k;
    logic             r_rd_vld;
    logic [NR_W-1:0]  r_rd_k;
    logic             r_win_vld;
    logic [ROW_W-1:0] r_win_row;
    logic [COLS-1:0]  r_up;
    logic [COLS-1:0]  r_mid;
    logic [COLS-1:0]  r_dn;
    logic [COLS-1:0]  r_row0;
    logic [COLS-1:0]  row_in;

    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    logic [COLS-1:0]  mem_wdata;
    logic             mem_re;
    logic [ROW_W-1:0] mem_raddr;
    logic [COLS-1:0]  mem_rdata;

    logic [COLS-1:0]  lanes;
    logic [COLS-1:0]  row_next;
    t_row_ctl         row_ctl;
    logic             back_we;
    logic [ROW_W-1:0] out_idx;
    logic [COLS-1:0]  out_cells;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= RESET_ROWS;
            r_cfg_cols <= RESET_COLS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS: r_cfg_rows <= i_cfg_data[NR_W-1:0];
                CFG_COLS: r_cfg_cols <= i_cfg_data[NC_W-1:0];
                default:  ;
            endcase
        end
    end

    // Saturate the grid size in use
    always_comb begin
        if (r_cfg_rows < NR_W'(MIN_DIM)) begin
            nr = NR_W'(MIN_DIM);
        end else if (r_cfg_rows > NR_W'(ROWS)) begin
            nr = NR_W'(ROWS);
        end else begin
            nr = r_cfg_rows;
        end
        if (r_cfg_cols < NC_W'(MIN_DIM)) begin
            nc = NC_W'(MIN_DIM);
        end else if (r_cfg_cols > NC_W'(COLS)) begin
            nc = NC_W'(COLS);
        end else begin
            nc = r_cfg_cols;
        end
        for (int j = 0; j < COLS; j++) begin
            col_mask[j] = (NC_W'(j) < nc);
        end
    end

    assign nr_p1    = nr + NR_W'(1);
    assign last_col = COL_W'(nc - NC_W'(1));

    // Input channel
    assign s_row_index = i_s_tdata[ROW_W-1:0];
    assign s_row_cells = i_s_tdata[ROW_W+COLS-1:ROW_W];
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign load_we     = s_accept && (i_s_tuser == OP_LOAD) && (NR_W'(s_row_index) < nr);

    // Pipeline advances when the output register can take a row
    assign go = !o_m_tvalid || i_m_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input ready
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept && (i_s_tuser == OP_ADVANCE)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (go && r_win_vld && row_ctl.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Read issue: row nr-1 first, then rows 0 .. nr-1; the final wrap reuses saved row 0
    assign mem_re    = (r_state == S_RUN) && go && (r_iss_k <= nr);
    assign mem_raddr = (r_iss_k == '0) ? ROW_W'(nr - NR_W'(1)) : ROW_W'(r_iss_k - NR_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_k   <= '0;
            r_rd_vld  <= 1'b0;
            r_win_vld <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_iss_k   <= '0;
            r_rd_vld  <= 1'b0;
            r_win_vld <= 1'b0;
        end else if (go) begin
            if (r_iss_k <= nr_p1) begin
                r_rd_vld <= 1'b1;
                r_iss_k  <= r_iss_k + NR_W'(1);
            end else begin
                r_rd_vld <= 1'b0;
            end
            r_win_vld <= r_rd_vld && (r_rd_k >= NR_W'(2));
        end
    end

    // Row window: shift in the next row, keep the old row 0 for the bottom wrap
    assign row_in = (r_rd_k == nr_p1) ? r_row0 : (mem_rdata & col_mask);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && go) begin
            r_rd_k <= r_iss_k;
            if (r_rd_vld) begin
                r_up      <= r_mid;
                r_mid     <= r_dn;
                r_dn      <= row_in;
                r_win_row <= ROW_W'(r_rd_k - NR_W'(2));
                if (r_rd_k == NR_W'(1)) begin
                    r_row0 <= row_in;
                end
            end
        end
    end

    // Column lanes with horizontal wrap at the columns in use
    for (genvar j = 0; j < COLS; j++) begin : g_lane
        logic up_l, up_r, mid_l, mid_r, dn_l, dn_r;

        if (j == 0) begin : g_left_wrap
            assign up_l  = r_up[last_col];
            assign mid_l = r_mid[last_col];
            assign dn_l  = r_dn[last_col];
        end else begin : g_left
            assign up_l  = r_up[j-1];
            assign mid_l = r_mid[j-1];
            assign dn_l  = r_dn[j-1];
        end

        if (j == COLS - 1) begin : g_right_wrap
            assign up_r  = r_up[0];
            assign mid_r = r_mid[0];
            assign dn_r  = r_dn[0];
        end else begin : g_right
            assign up_r  = (last_col == COL_W'(j)) ? r_up[0]  : r_up[j+1];
            assign mid_r = (last_col == COL_W'(j)) ? r_mid[0] : r_mid[j+1];
            assign dn_r  = (last_col == COL_W'(j)) ? r_dn[0]  : r_dn[j+1];
        end

        tlg_lane u_lane (
            .i_nbrs  ({up_l, r_up[j], up_r, mid_l, mid_r, dn_l, r_dn[j], dn_r}),
            .i_alive (r_mid[j]),
            .o_next  (lanes[j])
        );
    end

    // Merge stage and output register
    assign row_ctl.fire  = (r_state == S_RUN) && r_win_vld;
    assign row_ctl.first = (r_win_row == '0);
    assign row_ctl.last  = (NR_W'(r_win_row) == (nr - NR_W'(1)));
    assign row_ctl.row   = r_win_row;

    tlg_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (row_ctl),
        .i_lanes     (lanes),
        .i_mask      (col_mask),
        .i_mid       (r_mid),
        .i_ready     (i_m_tready),
        .o_row_next  (row_next),
        .o_valid     (o_m_tvalid),
        .o_row_idx   (out_idx),
        .o_row_cells (out_cells),
        .o_last      (o_m_tlast),
        .o_stable    (o_m_tuser)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, out_cells, out_idx};

    // Grid write port: loads while idle, new rows while running
    assign back_we   = row_ctl.fire && go;
    assign mem_we    = load_we || back_we;
    assign mem_waddr = back_we ? r_win_row : s_row_index;
    assign mem_wdata = back_we ? row_next : (s_row_cells & col_mask);

    tlg_row_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Checks
    `TLG_ASSERT_IMP(a_stable_on_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast, "stable flag outside last row")
    `TLG_ASSERT_NXT(a_run_after_mid_row, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid, "generation ended before last row")
    `TLG_ASSERT_IMP(a_win_row_range, i_clk, i_rst_n, r_win_vld, NR_W'(r_win_row) < nr, "window row beyond rows in use")
    `TLG_ASSERT_NXT(a_out_index_step, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, !o_m_tvalid || (o_m_tdata[ROW_W-1:0] == $past(o_m_tdata[ROW_W-1:0]) + ROW_W'(1)), "row index skipped")

endmodule

[sim/tb_toroidal_life_generation_unit.sv]
// Self-checking testbench for the toroidal life generation unit (B3/S23 on a wrapped grid).
// Depends on tlg_pkg and toroidal_life_generation_unit; a local life predictor checks each row.
`timescale 1ns / 1ps

module tb_toroidal_life_generation_unit;
    import tlg_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_WAIT       = 18;
    localparam int SETTLE_CYCLES  = 48;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 240;
    localparam int SHOWN_FAULTS   = 10;

    typedef struct {
        logic              op;
        logic [ROW_W-1:0]  row;
        logic [COLS-1:0]   cells;
    } t_life_item;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [COLS-1:0]   cells;
        logic              last;
        logic              stable;
    } t_gen_row;

    // DUT connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [DATA_W-1:0]     i_s_tdata = '0;
    logic                  i_s_tuser = OP_LOAD;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state
    logic [COLS-1:0]       life_grid [ROWS];
    logic [NR_W-1:0]       rows_reg;
    logic [NC_W-1:0]       cols_reg;
    t_gen_row              gen_rows_due [$];
    t_life_item            pending_items [$];

    // Handshake bookkeeping
    bit                    s_took;
    bit                    m_took;
    bit                    src_burst;
    bit                    snk_burst;
    int                    snd_wait;
    int                    rcv_wait;
    int                    rcv_next;
    int                    hold_left;
    int                    hold_asked;
    int                    hold_served;
    int                    idle_cycles;

    // Run statistics
    int                    fault_count;
    int                    loads_taken;
    int                    advances_taken;
    int                    rows_checked;
    int                    reg_writes;
    int                    phase_count;

    toroidal_life_generation_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Saturated geometry seen by the grid
    function automatic int rows_used();
        int r;
        r = rows_reg;
        if (r < MIN_DIM) r = MIN_DIM;
        if (r > ROWS) r = ROWS;
        return r;
    endfunction

    function automatic int cols_used();
        int c;
        c = cols_reg;
        if (c < MIN_DIM) c = MIN_DIM;
        if (c > COLS) c = COLS;
        return c;
    endfunction

    function automatic logic [COLS-1:0] col_mask();
        int c;
        c = cols_used();
        return (c >= COLS) ? '1 : ((COLS'(1) << c) - COLS'(1));
    endfunction

    // Compute the next generation, queue its rows and replace the grid
    function automatic void step_generation();
        int nr, nc, up, dn, lf, rt, cnt;
        logic [COLS-1:0] nxt [ROWS];
        logic [COLS-1:0] mask;
        bit same;
        t_gen_row g;
        nr = rows_used();
        nc = cols_used();
        mask = col_mask();
        same = 1'b1;
        for (int r = 0; r < nr; r++) begin
            nxt[r] = '0;
            up = (r + nr - 1) % nr;
            dn = (r + 1) % nr;
            for (int c = 0; c < nc; c++) begin
                lf = (c + nc - 1) % nc;
                rt = (c + 1) % nc;
                cnt = 0;
                cnt += life_grid[up][lf];
                cnt += life_grid[up][c];
                cnt += life_grid[up][rt];
                cnt += life_grid[r][lf];
                cnt += life_grid[r][rt];
                cnt += life_grid[dn][lf];
                cnt += life_grid[dn][c];
                cnt += life_grid[dn][rt];
                if (cnt == BIRTH_COUNT || (life_grid[r][c] && cnt == SURVIVE_COUNT))
                    nxt[r][c] = 1'b1;
            end
            if (nxt[r] != (life_grid[r] & mask)) same = 1'b0;
        end
        for (int r = 0; r < nr; r++) begin
            life_grid[r] = nxt[r];
            g.row    = ROW_W'(r);
            g.cells  = nxt[r];
            g.last   = (r == nr - 1);
            g.stable = (r == nr - 1) && same;
            gen_rows_due.push_back(g);
        end
    endfunction

    function automatic void apply_item(t_life_item it);
        if (it.op == OP_LOAD) begin
            loads_taken++;
            if (it.row < rows_used()) life_grid[it.row] = it.cells & col_mask();
        end else begin
            advances_taken++;
            step_generation();
        end
    endfunction

    task automatic report_fault(string msg);
        if (fault_count < SHOWN_FAULTS) $display("[%0t] %s", $realtime, msg);
        fault_count++;
    endtask

    // Monitor: sample both channels at the rising edge, predict and compare
    always @(posedge i_clk) begin
        t_gen_row exp_row;
        logic [ROW_W-1:0] got_row;
        logic [COLS-1:0]  got_cells;
        s_took = i_s_tvalid && o_s_tready;
        m_took = o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                if (i_cfg_index == CFG_ROWS) rows_reg = i_cfg_data[NR_W-1:0];
                else if (i_cfg_index == CFG_COLS) cols_reg = i_cfg_data;
            end
            if (m_took) begin
                got_row   = o_m_tdata[ROW_W-1:0];
                got_cells = o_m_tdata[ROW_W +: COLS];
                if (gen_rows_due.size() == 0) begin
                    report_fault($sformatf("unexpected row %0d cells %h last %b stable %b",
                        got_row, got_cells, o_m_tlast, o_m_tuser));
                end else begin
                    exp_row = gen_rows_due.pop_front();
                    rows_checked++;
                    if (got_row !== exp_row.row || got_cells !== exp_row.cells ||
                        o_m_tlast !== exp_row.last || o_m_tuser !== exp_row.stable)
                        report_fault($sformatf(
                            "row mismatch: exp row %0d cells %h last %b stable %b, got row %0d cells %h last %b stable %b",
                            exp_row.row, exp_row.cells, exp_row.last, exp_row.stable,
                            got_row, got_cells, o_m_tlast, o_m_tuser));
                end
            end
            if (s_took) begin
                t_life_item it;
                it.op    = i_s_tuser;
                it.row   = i_s_tdata[ROW_W-1:0];
                it.cells = i_s_tdata[ROW_W +: COLS];
                apply_item(it);
            end
        end
        // Watchdog on cycles without any transaction
        if (s_took || m_took || (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_toroidal_life_generation_unit: errors");
            $finish;
        end
    end

    // Driver: offer pending items with a random gap after each
    always @(negedge i_clk) begin
        t_life_item it;
        if (i_rst_n && (!i_s_tvalid || s_took)) begin
            if (snd_wait > 0) begin
                snd_wait   <= snd_wait - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_s_tuser  <= it.op;
                i_s_tdata  <= {{PAD_W{1'b0}}, it.cells, it.row};
                i_s_tvalid <= 1'b1;
                snd_wait   <= src_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end
    end

    // Receiver: random stall after each accepted row
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (m_took) rcv_next = snk_burst ? 0 : $urandom_range(0, MAX_WAIT);
            else rcv_next = (rcv_wait > 0) ? rcv_wait - 1 : 0;
            rcv_wait   <= rcv_next;
            i_m_tready <= (rcv_next == 0) && (hold_left == 0);
        end
    end

    function automatic logic [COLS-1:0] random_cells();
        logic [COLS-1:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return a & b;
            1: return a | b;
            2: return a & b & {$urandom, $urandom};
            default: return a;
        endcase
    endfunction

    task automatic queue_item(logic op, logic [ROW_W-1:0] row, logic [COLS-1:0] cells);
        t_life_item it;
        it.op    = op;
        it.row   = row;
        it.cells = cells;
        pending_items.push_back(it);
    endtask

    task automatic queue_advance();
        queue_item(OP_ADVANCE, ROW_W'($urandom), random_cells());
    endtask

    // Wait until the block is idle and every expected row is in
    task automatic drain();
        while (pending_items.size() != 0 || i_s_tvalid || gen_rows_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int rows, int cols);
        drain();
        write_reg(CFG_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_COLS, CFG_DATA_W'(cols));
        phase_count++;
    endtask

    // Stimulus
    initial begin
        int nr, rows, cols, random_items, phase, phase_items, n;
        for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
        rows_reg = RESET_ROWS;
        cols_reg = RESET_COLS;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: empty grid, wrapped blinker, full rows, loads past the window
        queue_advance();
        queue_item(OP_LOAD, 5'd0, 64'h8000_0000_0000_0003);
        queue_item(OP_LOAD, 5'd24, 64'h0000_0000_0000_1C00);
        queue_item(OP_LOAD, 5'd25, '1);
        queue_item(OP_LOAD, 5'd31, '1);
        queue_item(OP_LOAD, 5'd12, '1);
        queue_advance();
        queue_advance();

        // Smallest grid; high bits dropped on load, row 3 outside the window
        set_geometry(MIN_DIM, MIN_DIM);
        queue_item(OP_LOAD, 5'd0, '1);
        queue_item(OP_LOAD, 5'd1, 64'h0000_0000_0000_0002);
        queue_item(OP_LOAD, 5'd2, 64'hAAAA_5555_AAAA_5555);
        queue_item(OP_LOAD, 5'd3, '1);
        queue_advance();
        queue_advance();

        // Full grid: park data in high columns and in row 30
        set_geometry(ROWS, COLS);
        queue_item(OP_LOAD, 5'd5, 64'hF000_0000_0000_0007);
        queue_item(OP_LOAD, 5'd30, 64'h0000_0700_0000_0000);
        // Narrow view: stale high columns ignored, rows past 8 untouched
        set_geometry(8, 10);
        queue_advance();
        // Out-of-range registers saturate; unknown index ignored
        set_geometry(0, 127);
        write_reg(CFG_IDX_W'(CFG_COLS + 1), '1);
        queue_advance();
        set_geometry(63, 2);
        queue_advance();
        set_geometry(ROWS, COLS);
        queue_advance();

        // Random phases of loads followed by advances
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                0: begin rows = ROWS;    cols = COLS;    end
                1: begin rows = MIN_DIM; cols = MIN_DIM; end
                2: begin rows = ROWS;    cols = MIN_DIM; end
                3: begin rows = MIN_DIM; cols = COLS;    end
                default: begin
                    rows = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(MIN_DIM, ROWS);
                    cols = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(MIN_DIM, COLS);
                end
            endcase
            set_geometry(rows, cols);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_COLS + 1, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            nr = rows_used();
            src_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            // Backpressure: hold the receiver while the sender keeps pushing
            if (phase == 2) hold_asked++;
            phase_items = 0;
            while (phase_items < 26) begin
                n = $urandom_range(2, 12);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 99) < 85)
                        queue_item(OP_LOAD, ROW_W'($urandom_range(0, nr - 1)), random_cells());
                    else
                        queue_item(OP_LOAD, ROW_W'($urandom), random_cells());
                end
                phase_items += n;
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) queue_advance();
                phase_items += n;
            end
            random_items += phase_items;
            phase++;
        end

        drain();
        if (gen_rows_due.size() != 0)
            report_fault($sformatf("%0d expected rows never arrived", gen_rows_due.size()));
        $display("Covered %0d loads and %0d advances, %0d rows checked,",
                 loads_taken, advances_taken, rows_checked);
        $display("%0d register writes over %0d geometry settings, %0d faults.",
                 reg_writes, phase_count, fault_count);
        if (fault_count == 0)
            $display("tb_toroidal_life_generation_unit: clean");
        else
            $display("tb_toroidal_life_generation_unit: errors");
        $finish;
    end

endmodule
